/* rtl/apch_pkg.sv */
// ----------------------------------------------------------------------------
// apch_pkg
// Shared constants and types for the aligned pair context histogram.
// ----------------------------------------------------------------------------
package apch_pkg;

  localparam int KMER_LEN  = 3;
  localparam int NEXT_SIZE = 25;
  localparam int CTX_SIZE  = 625;
  localparam int PAIR_SIZE = CTX_SIZE * NEXT_SIZE;
  localparam int CTX_W     = $clog2(CTX_SIZE);
  localparam int PAIR_W    = $clog2(PAIR_SIZE);
  localparam int SEEN_W    = 3;
  localparam int CNT_W     = 31;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [20:0] LOG_SCALE = 21'd1972830;
  localparam logic signed [12:0] ZERO_PENALTY = 13'sd1024;

  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] ctx;
    logic [CNT_W-1:0] pr;
  } score_req_t;

  function automatic logic [2:0] clamp_base(input logic [2:0] b);
    clamp_base = (b > 3'd4) ? 3'd4 : b;
  endfunction

endpackage

/* rtl/apch_log2.sv */
// ----------------------------------------------------------------------------
// apch_log2
// Sequential log2 in Q16: one squaring step per cycle.
// ----------------------------------------------------------------------------
module apch_log2 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [apch_pkg::CNT_W-1:0] value,
  output logic                      done,
  output logic [20:0]               result
);

  logic [4:0]  e_w;
  logic [31:0] m_r, m_nxt;
  logic [20:0] res_r, res_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] sq_w;

  always_comb begin
    e_w = 5'd0;
    for (int i = 0; i < apch_pkg::CNT_W; i++) begin
      if (value[i]) e_w = 5'(i);
    end
  end

  assign sq_w = (64'(m_r) * 64'(m_r)) >> 30;

  always_comb begin
    m_nxt = m_r;
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      m_nxt = 32'({1'b0, value} << (5'd30 - e_w));
      res_nxt = {e_w, 16'd0};
      cnt_nxt = 5'd16;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sq_w >= 64'h8000_0000) begin
        m_nxt = 32'(sq_w >> 1);
        res_nxt = res_r | (21'd1 << (cnt_r - 5'd1));
      end else begin
        m_nxt = 32'(sq_w);
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    m_r <= m_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign result = res_r;

endmodule

/* rtl/apch_score.sv */
// ----------------------------------------------------------------------------
// apch_score
// Score unit: two log2 units, difference, scale, round and offset add; a zero count gives the offset less ZERO_PENALTY.
// ----------------------------------------------------------------------------
module apch_score (
  input  logic                     clk,
  input  logic                     rst_n,
  input  apch_pkg::score_req_t     req,
  input  logic signed [10:0]       offset,
  output logic                     done,
  output logic signed [12:0]       score
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOG  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_RND  = 2'd3;

  logic [1:0]  st_r, st_nxt;
  logic        zero_r, zero_nxt;
  logic        ld_p, ld_c;
  logic [20:0] lp_w, lc_w;
  logic signed [22:0] d_w;
  logic signed [44:0] p_r, p_nxt;
  logic [44:0] mag_w;
  logic [12:0] rnd_w;
  logic signed [12:0] sc_r, sc_nxt;
  logic done_r, done_nxt;

  apch_log2 u_lp (.clk(clk), .rst_n(rst_n), .start(req.go), .value(req.pr),
                  .done(ld_p), .result(lp_w));
  apch_log2 u_lc (.clk(clk), .rst_n(rst_n), .start(req.go), .value(req.ctx),
                  .done(ld_c), .result(lc_w));

  assign d_w = 23'(signed'({2'b0, lp_w})) - 23'(signed'({2'b0, lc_w}));
  assign mag_w = p_r[44] ? 45'(-p_r) : 45'(p_r);
  assign rnd_w = 13'((mag_w + 45'(64'h8000_0000)) >> 32);

  always_comb begin
    st_nxt = st_r;
    zero_nxt = zero_r;
    p_nxt = p_r;
    sc_nxt = sc_r;
    done_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (req.go) begin
          zero_nxt = (req.pr == '0) || (req.ctx == '0);
          st_nxt = S_LOG;
        end
      end
      S_LOG: begin
        if (ld_p && ld_c) st_nxt = S_MUL;
      end
      S_MUL: begin
        p_nxt = 45'(d_w) * signed'({1'b0, 44'(apch_pkg::LOG_SCALE)});
        st_nxt = S_RND;
      end
      S_RND: begin
        if (zero_r) begin
          sc_nxt = 13'(offset) - apch_pkg::ZERO_PENALTY;
        end else if (p_r[44]) begin
          sc_nxt = 13'(offset) - signed'(rnd_w);
        end else begin
          sc_nxt = 13'(offset) + signed'(rnd_w);
        end
        done_nxt = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= done_nxt;
    end
    zero_r <= zero_nxt;
    p_r <= p_nxt;
    sc_r <= sc_nxt;
  end

  assign done = done_r;
  assign score = sc_r;

endmodule

/* rtl/aligned_pair_context_histogram.sv */
// ----------------------------------------------------------------------------
// aligned_pair_context_histogram
// Context and context-by-pair counters in two memories, with query scoring.
// Start and unused operations leave busy low; push takes a read, then a write
// back. Query runs memory read, 16 log2 squaring steps, scale and round, then
// raises its result strobe.
// After reset a clearing pass over all 15625 pair entries clears both
// memories, busy high throughout; no result back-pressure.
// ----------------------------------------------------------------------------
module aligned_pair_context_histogram (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_operation,
  input  logic [2:0]                        in_ref_base,
  input  logic [2:0]                        in_read_base,
  input  logic [9:0]                        in_query_context,
  input  logic [4:0]                        in_query_pair,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [10:0]                       cfg_score_offset,
  output logic                              out_valid,
  output logic [apch_pkg::CNT_W-1:0]        out_context_total,
  output logic [apch_pkg::CNT_W-1:0]        out_pair_total,
  output logic signed [12:0]                out_score
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_PUSH = 3'd2;
  localparam logic [2:0] S_QRD  = 3'd3;
  localparam logic [2:0] S_QSC  = 3'd4;

  localparam int CW = apch_pkg::CTX_W;
  localparam int PW = apch_pkg::PAIR_W;
  localparam int NW = apch_pkg::CNT_W;

  logic [NW-1:0] ctx_mem [apch_pkg::CTX_SIZE];
  logic [NW-1:0] pair_mem [apch_pkg::PAIR_SIZE];

  logic [2:0]  st_r, st_nxt;
  logic [PW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] hist_r, hist_nxt;
  logic [4:0]  lo_r, lo_nxt;
  logic [apch_pkg::SEEN_W-1:0] seen_r, seen_nxt;
  logic signed [10:0] off_r;
  logic        cnt_en_r, cnt_en_nxt;
  logic        qok_r, qok_nxt;
  logic [CW-1:0] caddr_r, caddr_nxt;
  logic [PW-1:0] paddr_r, paddr_nxt;
  logic [NW-1:0] crd_r, prd_r;
  logic [NW-1:0] qc_r, qc_nxt, qp_r, qp_nxt;
  logic        c_we, p_we;
  logic [CW-1:0] c_wa;
  logic [PW-1:0] p_wa;
  logic [NW-1:0] c_wd, p_wd;
  logic [4:0]  pair_w;
  logic        acc;
  logic        sc_done;
  logic signed [12:0] sc_w;
  apch_pkg::score_req_t req;

  assign acc = start && !busy;
  assign busy = (st_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign pair_w = 5'(apch_pkg::clamp_base(in_ref_base)) * 5'd5
                + 5'(apch_pkg::clamp_base(in_read_base));

  always_comb begin
    st_nxt = st_r;
    clr_nxt = clr_r;
    hist_nxt = hist_r;
    lo_nxt = lo_r;
    seen_nxt = seen_r;
    cnt_en_nxt = cnt_en_r;
    qok_nxt = qok_r;
    caddr_nxt = caddr_r;
    paddr_nxt = paddr_r;
    qc_nxt = qc_r;
    qp_nxt = qp_r;
    c_we = 1'b0;
    p_we = 1'b0;
    c_wa = caddr_r;
    p_wa = paddr_r;
    c_wd = '0;
    p_wd = '0;
    req = '0;
    unique case (st_r)
      S_CLR: begin
        c_we = (clr_r < PW'(apch_pkg::CTX_SIZE));
        c_wa = CW'(clr_r);
        p_we = 1'b1;
        p_wa = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == PW'(apch_pkg::PAIR_SIZE - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          priority if (in_operation == apch_pkg::OP_START) begin
            hist_nxt = '0;
            lo_nxt = '0;
            seen_nxt = '0;
          end else if (in_operation == apch_pkg::OP_PUSH) begin
            caddr_nxt = hist_r;
            paddr_nxt = PW'(hist_r) * PW'(apch_pkg::NEXT_SIZE) + PW'(pair_w);
            cnt_en_nxt = (seen_r >= apch_pkg::SEEN_W'(apch_pkg::KMER_LEN - 1));
            if (seen_r < apch_pkg::SEEN_W'(apch_pkg::KMER_LEN - 1))
              seen_nxt = seen_r + 1'b1;
            hist_nxt = CW'(lo_r) * CW'(apch_pkg::NEXT_SIZE) + CW'(pair_w);
            lo_nxt = pair_w;
            st_nxt = S_PUSH;
          end else if (in_operation == apch_pkg::OP_QUERY) begin
            qok_nxt = (in_query_context < 10'(apch_pkg::CTX_SIZE))
                      && (in_query_pair < 5'(apch_pkg::NEXT_SIZE));
            caddr_nxt = CW'(in_query_context);
            paddr_nxt = PW'(in_query_context) * PW'(apch_pkg::NEXT_SIZE)
                      + PW'(in_query_pair);
            st_nxt = S_QRD;
          end else begin
            st_nxt = S_IDLE;
          end
        end
      end
      S_PUSH: begin
        if (cnt_en_r) begin
          c_we = 1'b1;
          c_wd = (crd_r == apch_pkg::COUNT_MAX) ? crd_r : crd_r + 1'b1;
          p_we = 1'b1;
          p_wd = (prd_r == apch_pkg::COUNT_MAX) ? prd_r : prd_r + 1'b1;
        end
        st_nxt = S_IDLE;
      end
      S_QRD: begin
        qc_nxt = qok_r ? crd_r : '0;
        qp_nxt = qok_r ? prd_r : '0;
        req.go = 1'b1;
        req.ctx = qc_nxt;
        req.pr = qp_nxt;
        st_nxt = S_QSC;
      end
      S_QSC: begin
        if (sc_done) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (c_we) ctx_mem[c_wa] <= c_wd;
    crd_r <= ctx_mem[caddr_nxt];
  end

  always_ff @(posedge clk) begin
    if (p_we) pair_mem[p_wa] <= p_wd;
    prd_r <= pair_mem[paddr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      hist_r <= '0;
      lo_r <= '0;
      seen_r <= '0;
      off_r <= 11'sd100;
    end else begin
      st_r <= st_nxt;
      clr_r <= clr_nxt;
      hist_r <= hist_nxt;
      lo_r <= lo_nxt;
      seen_r <= seen_nxt;
      if (cfg_valid && cfg_ready) off_r <= signed'(cfg_score_offset);
    end
    cnt_en_r <= cnt_en_nxt;
    qok_r <= qok_nxt;
    caddr_r <= caddr_nxt;
    paddr_r <= paddr_nxt;
    qc_r <= qc_nxt;
    qp_r <= qp_nxt;
  end

  apch_score u_score (.clk(clk), .rst_n(rst_n), .req(req), .offset(off_r),
                      .done(sc_done), .score(sc_w));

  assign out_valid = sc_done && (st_r == S_QSC);
  assign out_context_total = qc_r;
  assign out_pair_total = qp_r;
  assign out_score = sc_w;

  a_out_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r) == S_QSC)
    else $error("result outside query");
  a_push_two: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_PUSH |=> st_r == S_IDLE)
    else $error("push overran");
  a_seen_cap: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= apch_pkg::SEEN_W'(apch_pkg::KMER_LEN - 1))
    else $error("pairs seen overflow");

endmodule
